### hdl/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package b64d_pkg;

  localparam int unsigned CountW = 32;
  localparam logic [CountW-1:0] COUNT_MAX = '1;
  localparam logic [CountW-1:0] LIMIT_RESET = '1;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;
  // offsets that move a character onto its sextet value (mod 256)
  localparam logic [7:0] OFS_LOWER = 8'd71;
  localparam logic [7:0] OFS_DIGIT = 8'd4;

  // Work handed from front to back: up to three candidate bytes, oldest first.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              byte_valid;
    logic              last_result;
    logic [CountW-1:0] total_count;
  } result_t;

endpackage
`default_nettype wire

### hdl/b64d_fifo.sv
// Small register-based FIFO used as the job queue and the result queue.
// No package dependency.
`default_nettype none
module b64d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full    = (cnt_r == DEPTH_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : AW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : AW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

### hdl/b64d_front.sv
// Front end: maps characters to sextets, gathers groups and builds byte jobs.
// Depends on b64d_pkg.
`default_nettype none
module b64d_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   char_code,
  input  wire logic         last_char,
  output b64d_pkg::job_t    job,
  output logic              job_push
);

  logic [17:0] group_r, group_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        is_sextet;
  logic [5:0]  sextet;
  logic [23:0] word;
  logic [17:0] g_a;
  logic [1:0]  c_a;

  always_comb begin
    is_sextet = 1'b1;
    sextet    = '0;
    if (char_code >= b64d_pkg::CHAR_UPPER_A && char_code <= b64d_pkg::CHAR_UPPER_Z) begin
      sextet = 6'(char_code - b64d_pkg::CHAR_UPPER_A);
    end else if (char_code >= b64d_pkg::CHAR_LOWER_A &&
                 char_code <= b64d_pkg::CHAR_LOWER_Z) begin
      sextet = 6'(char_code - b64d_pkg::OFS_LOWER);
    end else if (char_code >= b64d_pkg::CHAR_DIGIT_0 &&
                 char_code <= b64d_pkg::CHAR_DIGIT_9) begin
      sextet = 6'(char_code + b64d_pkg::OFS_DIGIT);
    end else if (char_code == b64d_pkg::CHAR_PLUS) begin
      sextet = b64d_pkg::SEXTET_PLUS;
    end else if (char_code == b64d_pkg::CHAR_SLASH) begin
      sextet = b64d_pkg::SEXTET_SLASH;
    end else begin
      is_sextet = 1'b0;
    end
  end

  always_comb begin
    job        = '0;
    job.last   = last_char;
    word       = {group_r, sextet};
    g_a        = group_r;
    c_a        = count_r;
    if (is_sextet) begin
      if (count_r != 2'd3) begin
        g_a = {group_r[11:0], sextet};
        c_a = 2'(count_r + 2'd1);
      end else begin
        job.data[0] = word[23:16];
        job.data[1] = word[15:8];
        job.data[2] = word[7:0];
        job.nbytes  = 2'd3;
        g_a         = '0;
        c_a         = '0;
      end
    end
    // flush the partial group on the final character
    if (last_char) begin
      case (c_a)
        2'd1: begin
          job.data[0] = {g_a[5:0], 2'b00};
          job.nbytes  = 2'd1;
        end
        2'd2: begin
          job.data[0] = g_a[11:4];
          job.nbytes  = 2'd1;
        end
        2'd3: begin
          job.data[0] = g_a[17:10];
          job.data[1] = g_a[9:2];
          job.nbytes  = 2'd2;
        end
        default: begin
        end
      endcase
      g_a = '0;
      c_a = '0;
    end
    group_nxt = accept ? g_a : group_r;
    count_nxt = accept ? c_a : count_r;
    job_push  = accept && (job.nbytes != 2'd0 || last_char);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      count_r <= '0;
    end else begin
      group_r <= group_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/b64d_back.sv
// Back end: walks the bytes of each job, keeps the stream byte count and
// applies the output limit. Depends on b64d_pkg.
`default_nettype none
module b64d_back (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [b64d_pkg::CountW-1:0]        cfg_wr_data,
  input  wire b64d_pkg::job_t                     job,
  input  wire logic                               job_valid,
  output logic                                    job_pop,
  output b64d_pkg::result_t                       res,
  output logic                                    res_push,
  input  wire logic                               res_full
);

  logic [b64d_pkg::CountW-1:0] limit_r;
  logic [b64d_pkg::CountW-1:0] cnt_r, cnt_nxt;
  logic [1:0]                  k_r, k_nxt;
  logic [b64d_pkg::CountW:0]   sum;
  logic [b64d_pkg::CountW-1:0] total_sat;
  logic [b64d_pkg::CountW-1:0] cnt_inc;
  logic [1:0]                  rem;
  logic                        fire, has_byte, emit, step_done;

  assign fire      = job_valid && !res_full;
  assign has_byte  = (k_r < job.nbytes);
  assign emit      = has_byte && (cnt_r < limit_r);
  assign rem       = 2'(job.nbytes - k_r);
  assign sum       = {1'b0, cnt_r} + (b64d_pkg::CountW + 1)'(rem);
  assign total_sat = sum[b64d_pkg::CountW] ? b64d_pkg::COUNT_MAX
                                           : sum[b64d_pkg::CountW-1:0];
  assign cnt_inc   = b64d_pkg::CountW'(cnt_r + 1'b1);
  // once a byte lands on the limit, nothing later in the stream is emitted
  assign step_done = (2'(k_r + 2'd1) == job.nbytes) || (cnt_inc == limit_r);

  always_comb begin
    res      = '0;
    res_push = 1'b0;
    job_pop  = 1'b0;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    if (fire) begin
      if (emit) begin
        res.data_byte  = job.data[k_r];
        res.byte_valid = 1'b1;
        res_push       = 1'b1;
        if (step_done) begin
          job_pop = 1'b1;
          k_nxt   = '0;
          if (job.last) begin
            res.last_result = 1'b1;
            res.total_count = total_sat;
            cnt_nxt         = '0;
          end else begin
            cnt_nxt = total_sat;
          end
        end else begin
          k_nxt   = 2'(k_r + 2'd1);
          cnt_nxt = cnt_inc;
        end
      end else begin
        // count the remaining bytes and drop them; bare marker on stream end
        job_pop = 1'b1;
        k_nxt   = '0;
        if (job.last) begin
          res.last_result = 1'b1;
          res.total_count = total_sat;
          res_push        = 1'b1;
          cnt_nxt         = '0;
        end else begin
          cnt_nxt = total_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= b64d_pkg::LIMIT_RESET;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      cnt_r <= cnt_nxt;
      k_r   <= k_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/base64_stream_decoder_top.sv
// Base64 stream decoder (standard alphabet), queue-style ports on both sides.
// Instantiates b64d_front, b64d_fifo (job and result queues), b64d_back.
//
// Input: drive in_char_code/in_last_char with in_push; a beat is taken at an
// edge where in_push is high and in_full is low. Characters outside the
// alphabet (padding, whitespace, anything else) are dropped. in_last_char
// closes the stream: the partial group is flushed and the byte total is
// reported on the final result, which has out_last_result set.
// Output: while out_empty is low the oldest result is on the out_ ports;
// out_pop takes it. A stream end with no byte to emit gives one result with
// out_byte_valid low.
// Throughput: one character per cycle at the input while in_full is low. The
// back end emits one byte per cycle while the result queue is not full, so a
// group of four characters gives the back end three bytes to walk; the job
// queue absorbs the difference (output averages three bytes per four
// characters). Path: a byte passes through the job queue, then the result queue.
// Stall: when the result queue fills, the back end holds; when the job queue
// fills, in_full rises. cfg_wr_en/cfg_wr_data set the output limit; write it
// only while the block is idle.
// Reset: queues empty, group and byte count cleared, limit all ones.
`default_nettype none
module base64_stream_decoder_top #(
  parameter int unsigned JOB_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [31:0]                 cfg_wr_data,
  input  wire logic [7:0]                  in_char_code,
  input  wire logic                        in_last_char,
  input  wire logic                        in_push,
  output logic                             in_full,
  output logic [7:0]                       out_data_byte,
  output logic                             out_byte_valid,
  output logic                             out_last_result,
  output logic [31:0]                      out_total_count,
  output logic                             out_empty,
  input  wire logic                        out_pop
);

  localparam int unsigned JobW = $bits(b64d_pkg::job_t);
  localparam int unsigned ResW = $bits(b64d_pkg::result_t);
  localparam int unsigned JqDepth = (JOB_DEPTH < 2) ? 2 : JOB_DEPTH;

  b64d_pkg::job_t    fe_job, bk_job;
  b64d_pkg::result_t bk_res, oq_res;
  logic [JobW-1:0]   bk_job_bits;
  logic [ResW-1:0]   oq_res_bits;
  logic              accept, fe_push, jq_empty, bk_pop, bk_push, oq_full;

  assign accept = in_push && !in_full;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .char_code (in_char_code),
    .last_char (in_last_char),
    .job       (fe_job),
    .job_push  (fe_push)
  );

  b64d_fifo #(.WIDTH(JobW), .DEPTH(JqDepth)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fe_push),
    .din   (fe_job),
    .full  (in_full),
    .pop   (bk_pop),
    .dout  (bk_job_bits),
    .empty (jq_empty)
  );

  assign bk_job = bk_job_bits;

  b64d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .job         (bk_job),
    .job_valid   (!jq_empty),
    .job_pop     (bk_pop),
    .res         (bk_res),
    .res_push    (bk_push),
    .res_full    (oq_full)
  );

  b64d_fifo #(.WIDTH(ResW), .DEPTH(2)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (bk_push),
    .din   (bk_res),
    .full  (oq_full),
    .pop   (out_pop),
    .dout  (oq_res_bits),
    .empty (out_empty)
  );

  assign oq_res          = oq_res_bits;
  assign out_data_byte   = oq_res.data_byte;
  assign out_byte_valid  = oq_res.byte_valid;
  assign out_last_result = oq_res.last_result;
  assign out_total_count = oq_res.total_count;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    bk_push |-> !oq_full)
    else $error("result pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_pop |-> !jq_empty)
    else $error("job popped from empty queue");

  a_bare_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_byte_valid) |-> out_last_result)
    else $error("result without a byte is not a stream end");

  a_total_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_last_result) |-> (out_total_count == '0))
    else $error("non-final result carries a total");

endmodule
`default_nettype wire
